// File: src/upf_pkg.sv
package upf_pkg;

    // build limits
    localparam int MAX_ROW_BYTES   = 16384;
    localparam int MAX_PIXEL_BYTES = 8;

    // derived widths
    localparam int COL_W = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W = $clog2(MAX_ROW_BYTES) + 1;
    localparam int PIX_W = $clog2(MAX_PIXEL_BYTES);

    // register field widths
    localparam int BPP_W = 4;
    localparam int RB_W  = 15;

    // register addresses (word index)
    localparam logic REG_BPP = 1'b0;
    localparam logic REG_RB  = 1'b1;

    // filter codes
    localparam logic [2:0] CODE_NONE    = 3'd0;
    localparam logic [2:0] CODE_SUB     = 3'd1;
    localparam logic [2:0] CODE_UP      = 3'd2;
    localparam logic [2:0] CODE_AVERAGE = 3'd3;
    localparam logic [2:0] CODE_PAETH   = 3'd4;
    localparam logic [2:0] CODE_BAD     = 3'd5;

    // control carried with an item in the working stage
    typedef struct packed {
        logic             is_code;
        logic             first_row;
        logic             last;
        logic             bad;
        logic [2:0]       filt;
        logic [COL_W-1:0] col;
    } t_item_ctl;

    function automatic logic [7:0] absdiff8(input logic [7:0] p, input logic [7:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    // paeth predictor, ties prefer a, then b, then c
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [7:0] da;
        logic [7:0] db;
        logic [8:0] sab;
        logic [8:0] scc;
        logic [8:0] dc;
        da  = absdiff8(b, c);
        db  = absdiff8(a, c);
        sab = {1'b0, a} + {1'b0, b};
        scc = {c, 1'b0};
        dc  = (sab >= scc) ? (sab - scc) : (scc - sab);
        if (({1'b0, da} <= {1'b0, db}) && ({1'b0, da} <= dc)) begin
            return a;
        end else if ({1'b0, db} <= dc) begin
            return b;
        end
        return c;
    endfunction

endpackage

// File: src/upf_regs.sv
module upf_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [upf_pkg::PIX_W-1:0] o_bpp_idx,
    output logic [upf_pkg::ROW_W-1:0] o_row_len
);
    import upf_pkg::*;

    logic [BPP_W-1:0] r_bpp;
    logic [RB_W-1:0]  r_rb;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_W'(4);
            r_rb  <= RB_W'(4);
        end else if (wr) begin
            unique case (paddr[2])
                REG_BPP: r_bpp <= pwdata[BPP_W-1:0];
                REG_RB:  r_rb  <= pwdata[RB_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_BPP: prdata = {{(32-BPP_W){1'b0}}, r_bpp};
            REG_RB:  prdata = {{(32-RB_W){1'b0}}, r_rb};
            default: prdata = '0;
        endcase
    end

    // clamp pixel size to 1..MAX_PIXEL_BYTES, as index of the left tap
    always_comb begin
        if (r_bpp == '0) begin
            o_bpp_idx = '0;
        end else if (32'(r_bpp) > MAX_PIXEL_BYTES) begin
            o_bpp_idx = PIX_W'(MAX_PIXEL_BYTES - 1);
        end else begin
            o_bpp_idx = PIX_W'(r_bpp - BPP_W'(1));
        end
    end

    // clamp row length to 1..MAX_ROW_BYTES
    always_comb begin
        if (r_rb == '0) begin
            o_row_len = ROW_W'(1);
        end else if (32'(r_rb) > MAX_ROW_BYTES) begin
            o_row_len = ROW_W'(MAX_ROW_BYTES);
        end else begin
            o_row_len = ROW_W'(r_rb);
        end
    end

endmodule

// File: src/upf_line_buf.sv
module upf_line_buf (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [upf_pkg::COL_W-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_rd_en,
    input  logic [upf_pkg::COL_W-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import upf_pkg::*;

    logic [7:0] r_mem [MAX_ROW_BYTES];
    logic [7:0] r_rd_data;

    // previous row store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/upf_front.sv
module upf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [7:0]                i_raw_byte,
    input  logic                      i_image_start,
    input  logic [upf_pkg::ROW_W-1:0] i_row_len,
    input  logic                      i_s1_adv,
    output logic                      o_s1_valid,
    output logic [7:0]                o_s1_raw,
    output upf_pkg::t_item_ctl        o_s1_ctl,
    output logic                      o_rd_en,
    output logic [upf_pkg::COL_W-1:0] o_rd_addr
);
    import upf_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [2:0]       r_filt;
    logic             r_first;
    logic             r_await;
    logic             r_s1_valid;
    logic [7:0]       r_s1_raw;
    t_item_ctl        r_s1_ctl;

    logic             is_code;
    logic             last;
    logic [2:0]       code_in;
    t_item_ctl        n_ctl;

    assign is_code = i_image_start || r_await;
    assign last    = (ROW_W'(r_col) + ROW_W'(1)) >= i_row_len;
    assign code_in = (i_raw_byte > 8'd4) ? CODE_BAD : i_raw_byte[2:0];

    // control for the item entering the working stage
    always_comb begin
        n_ctl.is_code   = is_code;
        n_ctl.first_row = r_first;
        n_ctl.last      = last;
        n_ctl.bad       = (r_filt == CODE_BAD);
        n_ctl.filt      = r_filt;
        n_ctl.col       = r_col;
    end

    // fetch the above byte as the item enters
    assign o_rd_en   = i_accept && !is_code;
    assign o_rd_addr = r_col;

    // row sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_filt  <= CODE_NONE;
            r_first <= 1'b1;
            r_await <= 1'b1;
        end else if (i_accept) begin
            if (is_code) begin
                if (i_image_start) begin
                    r_first <= 1'b1;
                end
                r_filt  <= code_in;
                r_col   <= '0;
                r_await <= 1'b0;
            end else if (last) begin
                r_await <= 1'b1;
                r_first <= 1'b0;
                r_col   <= '0;
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // working stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_raw <= i_raw_byte;
            r_s1_ctl <= n_ctl;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_raw   = r_s1_raw;
    assign o_s1_ctl   = r_s1_ctl;

endmodule

// File: src/upf_recon.sv
module upf_recon (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s1_valid,
    input  logic [7:0]                i_s1_raw,
    input  upf_pkg::t_item_ctl        i_s1_ctl,
    input  logic [7:0]                i_above,
    input  logic [upf_pkg::PIX_W-1:0] i_bpp_idx,
    input  logic                      i_out_stall,
    output logic                      o_s1_adv,
    output logic                      o_wr_en,
    output logic [upf_pkg::COL_W-1:0] o_wr_addr,
    output logic [7:0]                o_wr_data,
    output logic                      o_out_valid,
    output logic [7:0]                o_pixel_byte,
    output logic                      o_row_end,
    output logic                      o_bad_filter
);
    import upf_pkg::*;

    logic [7:0] r_left [MAX_PIXEL_BYTES];
    logic [7:0] r_upl  [MAX_PIXEL_BYTES];
    logic       r_out_valid;
    logic [7:0] r_pixel;
    logic       r_row_end;
    logic       r_bad;

    logic       out_free;
    logic       data_adv;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [8:0] sum_ab;
    logic [7:0] pred;
    logic [7:0] val;

    // a code item leaves without a result, a data item needs the output register
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_s1_adv = i_s1_valid && (i_s1_ctl.is_code || out_free);
    assign data_adv = o_s1_adv && !i_s1_ctl.is_code;

    // neighbors
    assign a      = r_left[i_bpp_idx];
    assign c      = r_upl[i_bpp_idx];
    assign b      = i_s1_ctl.first_row ? 8'd0 : i_above;
    assign sum_ab = {1'b0, a} + {1'b0, b};

    // predictor select
    always_comb begin
        case (i_s1_ctl.filt)
            CODE_SUB:     pred = a;
            CODE_UP:      pred = b;
            CODE_AVERAGE: pred = sum_ab[8:1];
            CODE_PAETH:   pred = paeth(a, b, c);
            default:      pred = 8'd0;
        endcase
    end

    assign val = i_s1_raw + pred;

    // write back into the previous row store
    assign o_wr_en   = data_adv;
    assign o_wr_addr = i_s1_ctl.col;
    assign o_wr_data = val;

    // left and upper-left history, cleared at each row start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i] <= 8'd0;
                r_upl[i]  <= 8'd0;
            end
        end else if (o_s1_adv) begin
            if (i_s1_ctl.is_code) begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    r_left[i] <= 8'd0;
                    r_upl[i]  <= 8'd0;
                end
            end else begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                    r_left[i] <= r_left[i-1];
                    r_upl[i]  <= r_upl[i-1];
                end
                r_left[0] <= val;
                r_upl[0]  <= b;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (data_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_adv) begin
            r_pixel   <= val;
            r_row_end <= i_s1_ctl.last;
            r_bad     <= i_s1_ctl.bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_pixel;
    assign o_row_end    = r_row_end;
    assign o_bad_filter = r_bad;

endmodule

// File: src/png_scanline_unfilter.sv
// PNG scanline unfilter: takes the inflated stream one byte per item and
// returns one reconstructed byte for every data byte (filter code bytes give
// no result). It sustains one item per clock cycle with no bubbles while the
// result side keeps up. An accepted item is registered in the working stage,
// where the above byte comes out of the registered read port of the previous
// row store, and its result is then registered in the result register, where
// it waits until it is taken by the result side. The previous
// row store is not cleared after reset, so the block is ready at once; every
// row of an image must be no longer than the rows written before it since
// reset, apart from the first row, which reads its above bytes as zero. A
// filter code above 4 passes the row through unfiltered with bad_filter set on
// each of its bytes, and image_start on any byte begins a new image at that byte.
module png_scanline_unfilter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_image_start,
    // result stream
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_byte,
    output logic        o_row_end,
    output logic        o_bad_filter,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import upf_pkg::*;

    logic [PIX_W-1:0] bpp_idx;
    logic [ROW_W-1:0] row_len;
    logic             in_acc;
    logic             s1_valid;
    logic             s1_adv;
    logic [7:0]       s1_raw;
    t_item_ctl        s1_ctl;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    // stall when the working stage is full and cannot move on
    assign o_stall = s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    upf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_bpp_idx (bpp_idx),
        .o_row_len (row_len)
    );

    upf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_raw_byte    (i_raw_byte),
        .i_image_start (i_image_start),
        .i_row_len     (row_len),
        .i_s1_adv      (s1_adv),
        .o_s1_valid    (s1_valid),
        .o_s1_raw      (s1_raw),
        .o_s1_ctl      (s1_ctl),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    upf_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    upf_recon u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1_raw     (s1_raw),
        .i_s1_ctl     (s1_ctl),
        .i_above      (rd_data),
        .i_bpp_idx    (bpp_idx),
        .i_out_stall  (i_stall),
        .o_s1_adv     (s1_adv),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_valid),
        .o_pixel_byte (o_pixel_byte),
        .o_row_end    (o_row_end),
        .o_bad_filter (o_bad_filter)
    );

    // a new result only comes from a data item leaving the working stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(o_valid) && o_valid) |-> $past(s1_valid && s1_adv && !s1_ctl.is_code))
        else $error("result appeared without a data item");

    // an image start byte always enters as a filter code
    a_start_is_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_image_start) |=> (s1_valid && s1_ctl.is_code))
        else $error("image start not taken as filter code");

    // the line buffer is written only by a data item in the working stage
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (s1_valid && !s1_ctl.is_code && (wr_addr == s1_ctl.col)))
        else $error("line buffer write without data item");

endmodule
